// ===== design/imh_pkg.sv =====
// ---------------------------------------------------------------------------
// imh_pkg
// Shared request and status codes, widths and sizes for the indexed min-heap.
// ---------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
    // ids and heap positions share one width
    localparam int ADDR_W   = 10;
    localparam int CAPACITY = 1 << ADDR_W;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;
    localparam int ID_W     = ADDR_W;
    // flipping the sign bit makes unsigned compare order signed keys
    localparam logic [KEY_W-1:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_BUILD  = 3'd1;
    localparam logic [2:0] REQ_TAKE   = 3'd2;
    localparam logic [2:0] REQ_CHANGE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BAD_ID  = 3'd3;
    localparam logic [2:0] ST_LOADED  = 3'd4;
endpackage
`default_nettype wire

// ===== design/indexed_min_heap.sv =====
// Load, clear, build of an empty or already built store and rejected requests pass
// their result straight from S_DONE to the output register; take and change first
// sink or raise the moved entry level by level before S_DONE.
// Build sinks every inner node in turn, from the last one down to the root.
// One request at a time; a waiting result holds only the next result, not the input.
// Reset clears counts, flags and the result register; the memories are not cleared.
// ---------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with id-to-position map, driven by a sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [2:0]                        req_type,
    input  wire logic [imh_pkg::ID_W-1:0]          node_id,
    input  wire logic signed [imh_pkg::KEY_W-1:0]  key_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [2:0]                             status,
    output logic [imh_pkg::ID_W-1:0]               out_id,
    output logic signed [imh_pkg::KEY_W-1:0]       out_key
);
    localparam int AW = imh_pkg::ADDR_W;
    localparam int CW = imh_pkg::CNT_W;
    localparam int KW = imh_pkg::KEY_W;
    localparam logic [CW-1:0] CAP = CW'(imh_pkg::CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE, S_BUILD_NEXT, S_SINK_RD, S_SINK_LD, S_SINK_START, S_SINK_L,
        S_SINK_R, S_SINK_CMP, S_RISE_START, S_RISE_CMP, S_PLACE,
        S_TAKE_RD0, S_TAKE_RD1, S_TAKE_W, S_CHG_RD, S_CHG_DEC, S_DONE
    } state_t;

    // heap memory (key with biased sign, id) and position memory
    logic [KW-1:0] key_mem [imh_pkg::CAPACITY];
    logic [AW-1:0] id_mem  [imh_pkg::CAPACITY];
    logic [AW-1:0] pos_mem [imh_pkg::CAPACITY];

    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [KW-1:0] h_wk, h_rk;
    logic [AW-1:0] h_wi, h_ri;
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic [AW-1:0] p_wd, p_rd;

    state_t        state_reg;
    logic [CW-1:0] live_reg, loaded_reg, bi_reg;
    logic          built_reg, from_build_reg;
    logic [KW-1:0] key_reg;      // biased new key
    logic [AW-1:0] pos_reg, pick_reg;
    logic [KW-1:0] ckey_reg, lkey_reg;  // carried and smaller-child keys
    logic [AW-1:0] cid_reg, lid_reg;
    logic [KW-1:0] rk_reg;
    logic [AW-1:0] rid_reg;
    logic [2:0]    res_st_reg;
    logic [AW-1:0] res_id_reg;
    logic [KW-1:0] res_key_reg;
    logic [2:0]    out_st_reg;
    logic [AW-1:0] out_id_reg;
    logic [KW-1:0] out_key_reg;
    logic          ov_reg;

    logic [CW-1:0] left_w;
    logic [CW:0]   right_w;
    logic [AW-1:0] up_w;
    logic [CW-1:0] last_w;
    logic [CW-1:0] bi_dec_w;
    logic          load_ok;
    logic          bad_id;
    logic          done_fire;
    logic [2:0]    acc_st;

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            key_mem[h_wa] <= h_wk;
            id_mem[h_wa]  <= h_wi;
        end
        h_rk <= key_mem[h_ra];
        h_ri <= id_mem[h_ra];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pos_mem[p_wa] <= p_wd;
        p_rd <= pos_mem[p_ra];
    end

    // child, parent and last positions
    assign left_w   = {pos_reg, 1'b1};
    assign right_w  = {1'b0, left_w} + (CW+1)'(1);
    assign up_w     = (pos_reg - AW'(1)) >> 1;
    assign last_w   = live_reg - CW'(1);
    assign bi_dec_w = bi_reg - CW'(1);

    assign load_ok   = (state_reg == S_IDLE) && in_valid && (req_type == imh_pkg::REQ_LOAD)
                       && !built_reg && (loaded_reg < CAP);
    assign bad_id    = {1'b0, node_id} >= loaded_reg;
    assign done_fire = (state_reg == S_DONE) && (!ov_reg || !out_stall);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign status    = out_st_reg;
    assign out_id    = out_id_reg;
    assign out_key   = out_key_reg;

    // status decided at the input transfer
    always_comb
    begin
        case (req_type)
            imh_pkg::REQ_LOAD:
            begin
                if (built_reg)
                    acc_st = imh_pkg::ST_LOADED;
                else if (loaded_reg >= CAP)
                    acc_st = imh_pkg::ST_FULL;
                else
                    acc_st = imh_pkg::ST_OK;
            end
            imh_pkg::REQ_TAKE:   acc_st = (live_reg == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
            imh_pkg::REQ_CHANGE: acc_st = bad_id ? imh_pkg::ST_BAD_ID : imh_pkg::ST_OK;
            default:             acc_st = imh_pkg::ST_OK;
        endcase
    end

    // memory port control
    always_comb
    begin
        h_we = 1'b0; h_wa = pos_reg; h_wk = ckey_reg; h_wi = cid_reg;
        h_ra = pos_reg;
        p_we = 1'b0; p_wa = cid_reg; p_wd = pos_reg; p_ra = node_id;
        case (state_reg)
            S_IDLE:
            begin
                if (load_ok)
                begin
                    h_we = 1'b1; h_wa = loaded_reg[AW-1:0];
                    h_wk = key_value ^ imh_pkg::SIGN_BIAS; h_wi = loaded_reg[AW-1:0];
                    p_we = 1'b1; p_wa = loaded_reg[AW-1:0]; p_wd = loaded_reg[AW-1:0];
                end
            end
            S_SINK_START: h_ra = left_w[AW-1:0];
            S_SINK_L:     h_ra = right_w[AW-1:0];
            S_SINK_CMP:
            begin
                // smaller child moves up into pos
                if (lkey_reg < ckey_reg)
                begin
                    h_we = 1'b1; h_wk = lkey_reg; h_wi = lid_reg;
                    p_we = 1'b1; p_wa = lid_reg;
                end
            end
            S_RISE_START: h_ra = up_w;
            S_RISE_CMP:
            begin
                // parent moves down into pos
                if (h_rk > ckey_reg)
                begin
                    h_we = 1'b1; h_wk = h_rk; h_wi = h_ri;
                    p_we = 1'b1; p_wa = h_ri;
                end
            end
            S_PLACE:
            begin
                h_we = 1'b1; p_we = 1'b1;
            end
            S_TAKE_RD0:   h_ra = '0;
            S_TAKE_RD1:   h_ra = last_w[AW-1:0];
            S_TAKE_W:
            begin
                h_we = 1'b1; h_wa = last_w[AW-1:0]; h_wk = rk_reg; h_wi = rid_reg;
                p_we = 1'b1; p_wa = rid_reg; p_wd = last_w[AW-1:0];
            end
            S_CHG_RD:     h_ra = p_rd;
            S_CHG_DEC:
            begin
                // a removed node only takes the new key
                if ({1'b0, pos_reg} >= live_reg)
                begin
                    h_we = 1'b1; h_wk = key_reg; h_wi = h_ri;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; live_reg <= '0; loaded_reg <= '0; bi_reg <= '0;
            built_reg <= 1'b0; from_build_reg <= 1'b0; key_reg <= '0;
            pos_reg <= '0; pick_reg <= '0; ckey_reg <= '0; lkey_reg <= '0;
            cid_reg <= '0; lid_reg <= '0; rk_reg <= '0; rid_reg <= '0;
            res_st_reg <= imh_pkg::ST_OK; res_id_reg <= '0; res_key_reg <= '0;
            out_st_reg <= imh_pkg::ST_OK; out_id_reg <= '0; out_key_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= done_fire || (ov_reg && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg <= key_value ^ imh_pkg::SIGN_BIAS;
                        res_st_reg <= acc_st;
                        res_id_reg <= load_ok ? loaded_reg[AW-1:0] : '0;
                        res_key_reg <= '0;
                        case (req_type)
                            imh_pkg::REQ_LOAD:
                            begin
                                if (load_ok)
                                    loaded_reg <= loaded_reg + CW'(1);
                                state_reg <= S_DONE;
                            end
                            imh_pkg::REQ_BUILD:
                            begin
                                if (!built_reg && loaded_reg != '0)
                                begin
                                    built_reg <= 1'b1; live_reg <= loaded_reg;
                                    bi_reg <= ((loaded_reg - CW'(1)) >> 1) + CW'(1);
                                    from_build_reg <= 1'b1;
                                    state_reg <= S_BUILD_NEXT;
                                end
                                else if (!built_reg)
                                begin
                                    built_reg <= 1'b1; live_reg <= loaded_reg;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_DONE;
                            end
                            imh_pkg::REQ_TAKE:
                                state_reg <= (live_reg == '0) ? S_DONE : S_TAKE_RD0;
                            imh_pkg::REQ_CHANGE:
                                state_reg <= bad_id ? S_DONE : S_CHG_RD;
                            imh_pkg::REQ_CLEAR:
                            begin
                                live_reg <= '0; loaded_reg <= '0; built_reg <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                // next inner node to sink, from the last one down to the root
                S_BUILD_NEXT:
                begin
                    if (bi_reg == '0)
                    begin
                        from_build_reg <= 1'b0; state_reg <= S_DONE;
                    end
                    else
                    begin
                        bi_reg <= bi_dec_w; pos_reg <= bi_dec_w[AW-1:0];
                        state_reg <= S_SINK_RD;
                    end
                end
                // read the node that sinks
                S_SINK_RD: state_reg <= S_SINK_LD;
                S_SINK_LD:
                begin
                    ckey_reg <= h_rk; cid_reg <= h_ri; state_reg <= S_SINK_START;
                end
                S_SINK_START:
                begin
                    if (left_w >= live_reg) state_reg <= S_PLACE;
                    else state_reg <= S_SINK_L;
                end
                S_SINK_L:
                begin
                    lkey_reg <= h_rk; lid_reg <= h_ri; pick_reg <= left_w[AW-1:0];
                    if (right_w < {1'b0, live_reg}) state_reg <= S_SINK_R;
                    else state_reg <= S_SINK_CMP;
                end
                // right child wins only when strictly smaller
                S_SINK_R:
                begin
                    if (h_rk < lkey_reg)
                    begin
                        lkey_reg <= h_rk; lid_reg <= h_ri; pick_reg <= right_w[AW-1:0];
                    end
                    state_reg <= S_SINK_CMP;
                end
                S_SINK_CMP:
                begin
                    if (lkey_reg < ckey_reg)
                    begin
                        pos_reg <= pick_reg; state_reg <= S_SINK_START;
                    end
                    else state_reg <= S_PLACE;
                end
                S_RISE_START:
                begin
                    if (pos_reg == '0) state_reg <= S_PLACE;
                    else state_reg <= S_RISE_CMP;
                end
                S_RISE_CMP:
                begin
                    if (h_rk > ckey_reg)
                    begin
                        pos_reg <= up_w; state_reg <= S_RISE_START;
                    end
                    else state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    state_reg <= from_build_reg ? S_BUILD_NEXT : S_DONE;
                end
                S_TAKE_RD0: state_reg <= S_TAKE_RD1;
                S_TAKE_RD1:
                begin
                    rk_reg <= h_rk; rid_reg <= h_ri; state_reg <= S_TAKE_W;
                end
                S_TAKE_W:
                begin
                    // last entry now in h_rk; root goes to the last slot
                    ckey_reg <= h_rk; cid_reg <= h_ri;
                    res_key_reg <= rk_reg ^ imh_pkg::SIGN_BIAS; res_id_reg <= rid_reg;
                    live_reg <= last_w;
                    pos_reg <= '0;
                    state_reg <= (last_w == '0) ? S_DONE : S_SINK_START;
                end
                S_CHG_RD:
                begin
                    pos_reg <= p_rd; state_reg <= S_CHG_DEC;
                end
                // a removed node ends here; a larger key sinks, any other rises
                S_CHG_DEC:
                begin
                    ckey_reg <= key_reg; cid_reg <= h_ri;
                    if ({1'b0, pos_reg} >= live_reg) state_reg <= S_DONE;
                    else if (key_reg > h_rk) state_reg <= S_SINK_START;
                    else state_reg <= S_RISE_START;
                end
                // hand the result to the output register once it is free
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        out_st_reg <= res_st_reg; out_id_reg <= res_id_reg;
                        out_key_reg <= res_key_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
